// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL files; only the top-level file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk; skip it while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Flag a condition that must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== design/gf16_pkg.sv =====
`default_nettype none

package gf16_pkg;

  localparam int FE_W = 16;

  localparam logic [FE_W-1:0] GF_REDUCE_LOW = 16'h002B;
  localparam logic [FE_W-1:0] GF_INV_EXP    = 16'hFFFE;

  localparam logic [1:0] KIND_MUL = 2'd0;
  localparam logic [1:0] KIND_POW = 2'd1;
  localparam logic [1:0] KIND_INV = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SQR,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic acc_step;
    logic sqr_step;
    logic emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exp_lsb;
    logic last;
    logic out_free;
  } dp_sts_t;

  // Carry-less product folded twice modulo x^16+x^5+x^3+x+1.
  function automatic logic [FE_W-1:0] gf_mul(input logic [FE_W-1:0] x,
                                             input logic [FE_W-1:0] y);
    logic [2*FE_W-2:0] prod;
    logic [FE_W+3:0]   fold;
    logic [FE_W-1:0]   r;
    prod = '0;
    for (int i = 0; i < FE_W; i++) begin
      if (y[i]) prod = prod ^ ({{(FE_W-1){1'b0}}, x} << i);
    end
    fold = {4'b0000, prod[FE_W-1:0]};
    for (int j = 0; j < FE_W-1; j++) begin
      if (prod[FE_W+j]) fold = fold ^ ({4'b0000, GF_REDUCE_LOW} << j);
    end
    r = fold[FE_W-1:0];
    for (int k = 0; k < 4; k++) begin
      if (fold[FE_W+k]) r = r ^ (GF_REDUCE_LOW << k);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/gf16_datapath.sv =====
`default_nettype none

module gf16_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire gf16_pkg::ctl_cmd_t      cmd,
  input  wire logic [1:0]              in_kind,
  input  wire logic [15:0]             in_operand_a,
  input  wire logic [15:0]             in_operand_b,
  input  wire logic                    out_ready,
  output gf16_pkg::dp_sts_t            sts,
  output logic                         out_valid,
  output logic [15:0]                  out_field_result
);
  import gf16_pkg::*;

  logic [FE_W-1:0] acc_r, acc_nxt;
  logic [FE_W-1:0] base_r, base_nxt;
  logic [FE_W-1:0] exp_r, exp_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic [FE_W-1:0] res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [FE_W-1:0] mul_x, mul_p;

  // One shared field multiplier: square base or fold base into acc.
  assign mul_x = cmd.sqr_step ? base_r : acc_r;
  assign mul_p = gf_mul(mul_x, base_r);

  always_comb begin
    acc_nxt  = acc_r;
    base_nxt = base_r;
    exp_nxt  = exp_r;
    cnt_nxt  = cnt_r;
    if (cmd.load) begin
      base_nxt = in_operand_a;
      cnt_nxt  = '0;
      exp_nxt  = (in_kind == KIND_INV) ? GF_INV_EXP : in_operand_b;
      unique case (in_kind)
        KIND_MUL: acc_nxt = in_operand_b;
        KIND_POW,
        KIND_INV: acc_nxt = 16'h0001;
        default:  acc_nxt = '0;
      endcase
    end else if (cmd.acc_step) begin
      acc_nxt = mul_p;
    end else if (cmd.sqr_step) begin
      base_nxt = mul_p;
      exp_nxt  = exp_r >> 1;
      cnt_nxt  = cnt_r + 4'd1;
    end
  end

  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      res_nxt       = acc_r;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.exp_lsb  = exp_r[0];
  assign sts.last     = (cnt_r == 4'hF);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_field_result = res_r;

endmodule

`default_nettype wire

// ===== design/gf16_ctrl.sv =====
`default_nettype none

module gf16_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_kind,
  input  wire gf16_pkg::dp_sts_t   sts,
  output logic                     in_ready,
  output gf16_pkg::ctl_cmd_t       cmd
);
  import gf16_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_kind)
            KIND_MUL:          state_nxt = ST_MUL;
            KIND_POW, KIND_INV: state_nxt = ST_ACC;
            default:           state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MUL: state_nxt = ST_DONE;
      ST_ACC: state_nxt = ST_SQR;
      ST_SQR: state_nxt = sts.last ? ST_DONE : ST_ACC;
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL:  cmd.acc_step = 1'b1;
      ST_ACC:  cmd.acc_step = sts.exp_lsb;
      ST_SQR:  cmd.sqr_step = 1'b1;
      ST_DONE: cmd.emit     = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/gf2_16_field_arith_unit_top.sv =====
// Channel   Ports                                          Direction
// request   in_valid in_ready in_kind in_operand_a/_b      in
// result    out_valid out_ready out_field_result           out
//
// One request at a time: in_ready is high only in the idle state, even while a
// result waits in the output register; a stalled result holds, and the next request
// then waits before its hand-off. A multiply uses the shared multiplier once;
// power and inverse walk 16 exponent bits, each an optional multiply and a squaring
// on the one shared multiplier; an unused kind goes straight to hand-off with 0.
// Reset (rst_n low, synchronous) idles the controller and drops out_valid.
`default_nettype none
`include "assert_macros.svh"

module gf2_16_field_arith_unit_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_operand_a,
  input  wire logic [15:0] in_operand_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_field_result
);
  import gf16_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Sequence load, multiply steps and result hand-off.
  gf16_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Hold operands, accumulator, exponent and the output register.
  gf16_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_kind          (in_kind),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .out_ready        (out_ready),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_field_result (out_field_result)
  );

  // An accepted request keeps the unit busy for at least the next cycle.
  `ASSERT_CLK(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")
  // Never overwrite a result that is still waiting to be taken.
  `ASSERT_NEVER(a_no_overwrite, cmd.emit && out_valid && !out_ready, "result overwritten")
  // A new result appears only as the controller hands one off.
  `ASSERT_CLK(a_valid_from_emit, $rose(out_valid) |-> $past(cmd.emit), "spurious result")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the GF(2^16) multiply / power / inverse unit.
// Requests come from a queue and a clocked driver, results go to a clocked
// monitor, and a field predictor inside the bench supplies the expected values.
module tb_top;
  import gf16_pkg::*;

  // Kind 3 has no operation behind it; the unit must still answer with 0.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int RANDOM_REQS      = 1450;
  localparam int CALM_TAIL        = 150;     // final requests run without idling
  localparam int LONG_HOLD_AT     = 400;     // accepted count that starts the long stall
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 60;      // settle time after the last result
  localparam int CYCLE_LIMIT      = 800000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] a;
    logic [15:0] b;
  } gf_req_t;

  typedef struct packed {
    gf_req_t     req;
    logic [15:0] elem;
  } gf_expect_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [15:0] in_operand_a = '0;
  logic [15:0] in_operand_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_field_result;

  gf_req_t    req_q[$];        // requests waiting for the driver
  gf_expect_t field_elem_q[$]; // predicted results, oldest first

  int req_total = 0;
  int sent_cnt = 0;           // requests put on the bus by the driver
  int acc_cnt = 0;            // requests taken by the unit
  int err_cnt = 0;
  int cycle_cnt = 0;
  int send_gap = 0;
  int ready_hold = 0;
  bit long_hold_done = 1'b0;

  gf2_16_field_arith_unit_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_field_result (out_field_result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Field predictor
  // ---------------------------------------------------------------------------

  // Shift-and-add product: walk the bits of y, doubling x modulo P each step.
  function automatic logic [15:0] field_mul(logic [15:0] x, logic [15:0] y);
    logic [15:0] acc;
    logic [15:0] sh;
    acc = '0;
    sh  = x;
    for (int i = 0; i < 16; i++) begin
      if (y[i]) acc = acc ^ sh;
      sh = sh[15] ? ({sh[14:0], 1'b0} ^ GF_REDUCE_LOW) : {sh[14:0], 1'b0};
    end
    return acc;
  endfunction

  // Right-to-left square-and-multiply; a zero exponent leaves the 1 in place.
  function automatic logic [15:0] field_pow(logic [15:0] base, logic [15:0] ex);
    logic [15:0] acc;
    logic [15:0] sq;
    acc = 16'h0001;
    sq  = base;
    for (int i = 0; i < 16; i++) begin
      if (ex[i]) acc = field_mul(acc, sq);
      sq = field_mul(sq, sq);
    end
    return acc;
  endfunction

  function automatic logic [15:0] field_result_of(gf_req_t r);
    case (r.kind)
      KIND_MUL: return field_mul(r.a, r.b);
      KIND_POW: return field_pow(r.a, r.b);
      KIND_INV: return field_pow(r.a, GF_INV_EXP);
      default:  return 16'h0000;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_req(logic [1:0] kind, logic [15:0] a, logic [15:0] b);
    gf_req_t r;
    r.kind = kind;
    r.a    = a;
    r.b    = b;
    req_q.push_back(r);
  endtask

  // Lean on the corner elements now and then; otherwise take any element.
  function automatic logic [15:0] pick_elem();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'hFFFF;
      3:       return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mix tiny exponents, the inverse exponent and arbitrary ones.
  function automatic logic [15:0] pick_exp();
    case ($urandom_range(0, 9))
      0, 1:    return 16'($urandom_range(0, 3));
      2:       return GF_INV_EXP;
      3:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic report_mismatch(gf_expect_t want, logic [15:0] got);
    $display("MISMATCH @%0t kind=%0d a=%04h b=%04h field_result got %04h want %04h",
             $realtime, want.req.kind, want.req.a, want.req.b, got, want.elem);
    err_cnt++;
  endtask

  task automatic report_unexpected(logic [15:0] got);
    $display("MISMATCH @%0t result %04h with no request outstanding", $realtime, got);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: change inputs on the falling edge only
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    gf_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || acc_cnt == sent_cnt) begin
      // The bus is free: either nothing was offered or the last request was taken.
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (req_q.size() != 0) begin
        nxt = req_q.pop_front();
        in_kind      <= nxt.kind;
        in_operand_a <= nxt.a;
        in_operand_b <= nxt.b;
        in_valid     <= 1'b1;
        sent_cnt++;
        // Insert an idle burst after this request, except in the calm tail.
        if (sent_cnt < req_total - CALM_TAIL && $urandom_range(0, 3) == 0)
          send_gap = $urandom_range(1, 14);
      end else begin
        in_valid <= 1'b0;
      end
    end
    // Otherwise hold valid and payload until the unit takes the request.
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stall bursts plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else if (!long_hold_done && acc_cnt >= LONG_HOLD_AT) begin
      // Back up the result path while the driver keeps offering requests.
      long_hold_done = 1'b1;
      ready_hold = LONG_HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (acc_cnt < req_total - CALM_TAIL && $urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(1, 14) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    gf_req_t    seen;
    gf_expect_t want;
    if (rst_n) begin
      // Predict on acceptance so the expectation is queued before any result.
      if (in_valid && in_ready) begin
        seen.kind = in_kind;
        seen.a    = in_operand_a;
        seen.b    = in_operand_b;
        want.req  = seen;
        want.elem = field_result_of(seen);
        field_elem_q.push_back(want);
        acc_cnt++;
      end
      if (out_valid && out_ready) begin
        if (field_elem_q.size() == 0) begin
          report_unexpected(out_field_result);
        end else begin
          want = field_elem_q.pop_front();
          if (out_field_result !== want.elem) report_mismatch(want, out_field_result);
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("gf2_16_field_arith_unit_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build stimulus, release reset, drain, judge
  // ---------------------------------------------------------------------------
  initial begin
    int pick;

    // Directed corners: operand extremes, reduction wrap, every kind.
    add_req(KIND_MUL, 16'h0000, 16'h0000);
    add_req(KIND_MUL, 16'hFFFF, 16'hFFFF);
    add_req(KIND_MUL, 16'h0001, 16'hA5C3);
    add_req(KIND_MUL, 16'h8000, 16'h0002);   // x^16 folds back to the low taps
    add_req(KIND_MUL, 16'hFFFF, 16'h0000);
    add_req(KIND_MUL, 16'h8000, 16'h8000);
    add_req(KIND_POW, 16'h0000, 16'h0000);   // zero to the zero power is one
    add_req(KIND_POW, 16'h1234, 16'h0000);
    add_req(KIND_POW, 16'h0000, 16'h0001);
    add_req(KIND_POW, 16'h0002, 16'hFFFF);
    add_req(KIND_POW, 16'hFFFF, 16'hFFFF);
    add_req(KIND_POW, 16'h8000, 16'h8000);
    add_req(KIND_POW, 16'h0003, 16'h0002);
    add_req(KIND_INV, 16'h0000, 16'hFFFF);   // zero has no inverse: result is zero
    add_req(KIND_INV, 16'h0001, 16'h0000);
    add_req(KIND_INV, 16'hFFFF, 16'h5A5A);
    add_req(KIND_INV, 16'h8000, 16'hFFFF);
    add_req(KIND_INV, 16'h0002, 16'h0001);
    add_req(KIND_UNUSED, 16'hFFFF, 16'hFFFF); // unused kind still answers with zero
    add_req(KIND_UNUSED, 16'h0000, 16'h0000);

    // Random bulk, weighted toward the multiplier-heavy kinds.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      add_req(KIND_MUL, pick_elem(), pick_elem());
      else if (pick < 65) add_req(KIND_POW, pick_elem(), pick_exp());
      else if (pick < 88) add_req(KIND_INV, pick_elem(), 16'($urandom_range(0, 65535)));
      else                add_req(KIND_UNUSED, pick_elem(), pick_elem());
    end
    req_total = req_q.size();

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Wait until every request went in and every result came back.
    while (req_q.size() != 0 || acc_cnt != req_total || field_elem_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0 && field_elem_q.size() == 0)
      $display("gf2_16_field_arith_unit_top regression: pass");
    else
      $display("gf2_16_field_arith_unit_top regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/gf16_pkg.sv
design/gf16_datapath.sv
design/gf16_ctrl.sv
design/gf2_16_field_arith_unit_top.sv
test/tb_top.sv
